// File: hdl/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and frame layout constants for the command frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [7:0] FLAG_RESET = 8'hAA;

  localparam logic [4:0] POS_FIRST      = 5'd0;
  localparam logic [4:0] POS_HDR_LAST   = 5'd3;
  localparam logic [4:0] POS_SUM_FIRST  = 5'd4;
  localparam logic [4:0] POS_SUM_LAST   = 5'd25;
  localparam logic [4:0] POS_CAP_LAST   = 5'd18;
  localparam logic [4:0] POS_CHK_LO     = 5'd26;
  localparam logic [4:0] POS_CHK_HI     = 5'd27;
  localparam logic [4:0] POS_TAIL_FIRST = 5'd28;
  localparam logic [4:0] POS_LAST       = 5'd31;

  localparam int CAP_DEPTH = 15;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_TAIL   = 2'd2,
    ST_BAD_CHECK  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] sequence_res;
    logic [15:0] detector_bias;
    logic [7:0]  control_param;
    logic [7:0]  frame_denoise;
    logic [7:0]  stride_diff;
    logic [7:0]  kernel_select;
    logic [7:0]  power_switch;
    logic [15:0] distance;
    logic [15:0] velocity;
    logic [15:0] temp_control;
  } cmd_fields_t;

endpackage

// File: hdl/cfd_field_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_field_store
// Holds frame bytes 4 to 18 and presents them as the decoded command fields.
// ----------------------------------------------------------------------------
module cfd_field_store (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [4:0]          pos,
  input  logic [7:0]          data,
  output cfd_pkg::cmd_fields_t fields
);

  logic [7:0] cap_r [cfd_pkg::CAP_DEPTH];
  logic [3:0] idx;

  assign idx = 4'(pos - cfd_pkg::POS_SUM_FIRST);

  always_ff @(posedge clk) begin
    if (wr_en && (pos inside {[cfd_pkg::POS_SUM_FIRST:cfd_pkg::POS_CAP_LAST]})) begin
      cap_r[idx] <= data;
    end
  end

  always_comb begin
    fields.sequence_res  = {cap_r[1], cap_r[0]};
    fields.detector_bias = {cap_r[3], cap_r[2]};
    fields.control_param = cap_r[4];
    fields.frame_denoise = cap_r[5];
    fields.stride_diff   = cap_r[6];
    fields.kernel_select = cap_r[7];
    fields.power_switch  = cap_r[8];
    fields.distance      = {cap_r[10], cap_r[9]};
    fields.velocity      = {cap_r[12], cap_r[11]};
    fields.temp_control  = {cap_r[14], cap_r[13]};
  end

endmodule

// File: hdl/command_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_deframer
// Checks 32-byte command frames and emits one decoded result per frame.
// ----------------------------------------------------------------------------
// Throughput is one byte per cycle but for byte 31 while a result is pending.
// Frame state updates are combinational; out_valid is registered from byte 31
// in the input register. Byte 31 waits there only while a result is pending.
// Synchronous active-low reset clears the byte count, checks and both valid
// flags and sets the flag byte to 0xAA; captured bytes are not reset.
module command_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_sequence_res,
  output logic [15:0] out_detector_bias,
  output logic [7:0]  out_control_param,
  output logic [7:0]  out_frame_denoise,
  output logic [7:0]  out_stride_diff,
  output logic [7:0]  out_kernel_select,
  output logic [7:0]  out_power_switch,
  output logic [15:0] out_distance,
  output logic [15:0] out_velocity,
  output logic [15:0] out_temp_control
);

  logic [7:0]  flag_byte_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic [4:0]  byte_count_r, byte_count_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic        header_good_r, header_good_nxt;
  logic        tail_good_r, tail_good_nxt;
  logic [7:0]  check_low_r;
  logic        out_valid_r;
  cfd_pkg::status_t     out_status_r, status_nxt;
  cfd_pkg::cmd_fields_t out_fields_r, fields;

  logic [4:0]  s1_pos;
  logic        is_flag, s1_last, out_free, s1_adv, launch;
  logic        hg_base, tg_base;
  logic [15:0] sum_base;

  assign is_flag  = (s1_byte_r == flag_byte_r);
  assign s1_pos   = s1_start_r ? cfd_pkg::POS_FIRST : byte_count_r;
  assign s1_last  = (s1_pos == cfd_pkg::POS_LAST);
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last || out_free);
  assign launch   = s1_adv && s1_last;
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    hg_base  = (s1_pos == cfd_pkg::POS_FIRST) ? 1'b1 : header_good_r;
    tg_base  = (s1_pos == cfd_pkg::POS_FIRST) ? 1'b1 : tail_good_r;
    sum_base = (s1_pos == cfd_pkg::POS_FIRST) ? 16'd0 : running_sum_r;

    header_good_nxt = (s1_pos <= cfd_pkg::POS_HDR_LAST) ? (hg_base && is_flag) : hg_base;
    tail_good_nxt   = (s1_pos >= cfd_pkg::POS_TAIL_FIRST) ? (tg_base && is_flag) : tg_base;

    if (s1_pos inside {[cfd_pkg::POS_SUM_FIRST:cfd_pkg::POS_SUM_LAST]}) begin
      running_sum_nxt = sum_base + {8'd0, s1_byte_r};
    end else if (s1_pos == cfd_pkg::POS_CHK_HI) begin
      running_sum_nxt = sum_base ^ {s1_byte_r, check_low_r};
    end else begin
      running_sum_nxt = sum_base;
    end

    byte_count_nxt = s1_pos + 5'd1;

    if (!header_good_nxt) begin
      status_nxt = cfd_pkg::ST_BAD_HEADER;
    end else if (!tail_good_nxt) begin
      status_nxt = cfd_pkg::ST_BAD_TAIL;
    end else if (running_sum_nxt != 16'd0) begin
      status_nxt = cfd_pkg::ST_BAD_CHECK;
    end else begin
      status_nxt = cfd_pkg::ST_OK;
    end
  end

  cfd_field_store u_store (
    .clk    (clk),
    .wr_en  (s1_adv),
    .pos    (s1_pos),
    .data   (s1_byte_r),
    .fields (fields)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_byte_r   <= cfd_pkg::FLAG_RESET;
      s1_valid_r    <= 1'b0;
      byte_count_r  <= 5'd0;
      running_sum_r <= 16'd0;
      header_good_r <= 1'b1;
      tail_good_r   <= 1'b1;
      check_low_r   <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        flag_byte_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        byte_count_r  <= byte_count_nxt;
        running_sum_r <= running_sum_nxt;
        header_good_r <= header_good_nxt;
        tail_good_r   <= tail_good_nxt;
        if (s1_pos == cfd_pkg::POS_CHK_LO) begin
          check_low_r <= s1_byte_r;
        end
      end
      if (launch) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_frame_start;
    end
    if (launch) begin
      out_status_r <= status_nxt;
      out_fields_r <= (status_nxt == cfd_pkg::ST_OK) ? fields : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_sequence_res  = out_fields_r.sequence_res;
  assign out_detector_bias = out_fields_r.detector_bias;
  assign out_control_param = out_fields_r.control_param;
  assign out_frame_denoise = out_fields_r.frame_denoise;
  assign out_stride_diff   = out_fields_r.stride_diff;
  assign out_kernel_select = out_fields_r.kernel_select;
  assign out_power_switch  = out_fields_r.power_switch;
  assign out_distance      = out_fields_r.distance;
  assign out_velocity      = out_fields_r.velocity;
  assign out_temp_control  = out_fields_r.temp_control;

`ifndef NO_ASSERTIONS
  a_launch_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    launch |=> out_valid_r)
    else $error("Result of the last byte was not presented.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !launch)
    else $error("Pending result was overwritten.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (byte_count_r == 5'($past(s1_pos) + 5'd1)))
    else $error("Byte count did not follow the processed item.");

  a_bad_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != cfd_pkg::ST_OK) |->
      (out_fields_r == '0))
    else $error("Failed frame carries nonzero fields.");
`endif

endmodule

// File: sim/cfd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_frame_checker
// Watches the configuration port and both channels of the command frame
// deframer. It keeps its own copy of the frame state and flag byte, predicts
// the result of every completed frame, and compares each accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cfd_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_sequence_res,
  input  logic [15:0] out_detector_bias,
  input  logic [7:0]  out_control_param,
  input  logic [7:0]  out_frame_denoise,
  input  logic [7:0]  out_stride_diff,
  input  logic [7:0]  out_kernel_select,
  input  logic [7:0]  out_power_switch,
  input  logic [15:0] out_distance,
  input  logic [15:0] out_velocity,
  input  logic [15:0] out_temp_control,
  output int          fail_count,
  output int          results_waiting
);

  typedef struct {
    cfd_pkg::status_t     status;
    cfd_pkg::cmd_fields_t fields;
  } frame_result_t;

  frame_result_t expected_frames[$];

  logic [7:0]  flag;
  logic [4:0]  next_pos;
  logic [15:0] sum_acc;
  logic        hdr_ok;
  logic        tail_ok;
  logic [7:0]  chk_lo;
  logic [7:0]  cap [cfd_pkg::CAP_DEPTH];
  int          mismatch_total = 0;

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatch_total++;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic start);
    logic [4:0]    p;
    frame_result_t r;
    p = start ? cfd_pkg::POS_FIRST : next_pos;
    if (p == cfd_pkg::POS_FIRST) begin
      sum_acc = '0;
      hdr_ok = 1'b1;
      tail_ok = 1'b1;
    end
    if (p <= cfd_pkg::POS_HDR_LAST) hdr_ok = hdr_ok && (b == flag);
    if (p >= cfd_pkg::POS_SUM_FIRST && p <= cfd_pkg::POS_SUM_LAST)
      sum_acc = sum_acc + 16'(b);
    if (p >= cfd_pkg::POS_SUM_FIRST && p <= cfd_pkg::POS_CAP_LAST)
      cap[p - cfd_pkg::POS_SUM_FIRST] = b;
    if (p == cfd_pkg::POS_CHK_LO) chk_lo = b;
    if (p == cfd_pkg::POS_CHK_HI) sum_acc = sum_acc ^ {b, chk_lo};
    if (p >= cfd_pkg::POS_TAIL_FIRST) tail_ok = tail_ok && (b == flag);
    if (p == cfd_pkg::POS_LAST) begin
      if (!hdr_ok) r.status = cfd_pkg::ST_BAD_HEADER;
      else if (!tail_ok) r.status = cfd_pkg::ST_BAD_TAIL;
      else if (sum_acc != '0) r.status = cfd_pkg::ST_BAD_CHECK;
      else r.status = cfd_pkg::ST_OK;
      r.fields = '0;
      if (r.status == cfd_pkg::ST_OK) begin
        r.fields.sequence_res  = {cap[1], cap[0]};
        r.fields.detector_bias = {cap[3], cap[2]};
        r.fields.control_param = cap[4];
        r.fields.frame_denoise = cap[5];
        r.fields.stride_diff   = cap[6];
        r.fields.kernel_select = cap[7];
        r.fields.power_switch  = cap[8];
        r.fields.distance      = {cap[10], cap[9]};
        r.fields.velocity      = {cap[12], cap[11]};
        r.fields.temp_control  = {cap[14], cap[13]};
      end
      expected_frames.push_back(r);
    end
    next_pos = p + 5'd1;
  endtask

  task automatic check_result();
    frame_result_t w;
    if (expected_frames.size() == 0) begin
      note_mismatch("result with no frame pending", {14'd0, out_status}, '0);
    end else begin
      w = expected_frames.pop_front();
      if (out_status !== w.status)
        note_mismatch("status", {14'd0, out_status}, {14'd0, w.status});
      if (out_sequence_res !== w.fields.sequence_res)
        note_mismatch("sequence_res", out_sequence_res, w.fields.sequence_res);
      if (out_detector_bias !== w.fields.detector_bias)
        note_mismatch("detector_bias", out_detector_bias, w.fields.detector_bias);
      if (out_control_param !== w.fields.control_param)
        note_mismatch("control_param", out_control_param, w.fields.control_param);
      if (out_frame_denoise !== w.fields.frame_denoise)
        note_mismatch("frame_denoise", out_frame_denoise, w.fields.frame_denoise);
      if (out_stride_diff !== w.fields.stride_diff)
        note_mismatch("stride_diff", out_stride_diff, w.fields.stride_diff);
      if (out_kernel_select !== w.fields.kernel_select)
        note_mismatch("kernel_select", out_kernel_select, w.fields.kernel_select);
      if (out_power_switch !== w.fields.power_switch)
        note_mismatch("power_switch", out_power_switch, w.fields.power_switch);
      if (out_distance !== w.fields.distance)
        note_mismatch("distance", out_distance, w.fields.distance);
      if (out_velocity !== w.fields.velocity)
        note_mismatch("velocity", out_velocity, w.fields.velocity);
      if (out_temp_control !== w.fields.temp_control)
        note_mismatch("temp_control", out_temp_control, w.fields.temp_control);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      flag = cfd_pkg::FLAG_RESET;
      next_pos = cfd_pkg::POS_FIRST;
      sum_acc = '0;
      hdr_ok = 1'b1;
      tail_ok = 1'b1;
      chk_lo = '0;
      for (int i = 0; i < cfd_pkg::CAP_DEPTH; i++) cap[i] = '0;
      expected_frames.delete();
    end else begin
      if (cfg_wr_en) flag = cfg_wr_data;
      if (in_valid && in_ready) take_byte(in_data_byte, in_frame_start);
      if (out_valid && out_ready) check_result();
    end
    fail_count <= mismatch_total;
    results_waiting <= expected_frames.size();
  end

endmodule

// File: sim/command_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_deframer_tb
// Drives command frames into the deframer with random gaps on both channels.
// A directed set of frames covers the field extremes, each failure status,
// their priority, wrap-around framing and a restart in mid-frame. Random
// phases under several flag bytes follow, mixing good, corrupted, truncated
// and noise input, with one long output stall. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module command_frame_deframer_tb;

  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_BYTES  = 200;
  localparam int LONG_HOLD    = 400;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_sequence_res;
  logic [15:0] out_detector_bias;
  logic [7:0]  out_control_param;
  logic [7:0]  out_frame_denoise;
  logic [7:0]  out_stride_diff;
  logic [7:0]  out_kernel_select;
  logic [7:0]  out_power_switch;
  logic [15:0] out_distance;
  logic [15:0] out_velocity;
  logic [15:0] out_temp_control;

  int          fail_count;
  int          results_waiting;
  int          cycle_count;
  int          hold_req;
  bit          quiet;
  logic [7:0]  flag_now;

  command_frame_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_sequence_res  (out_sequence_res),
    .out_detector_bias (out_detector_bias),
    .out_control_param (out_control_param),
    .out_frame_denoise (out_frame_denoise),
    .out_stride_diff   (out_stride_diff),
    .out_kernel_select (out_kernel_select),
    .out_power_switch  (out_power_switch),
    .out_distance      (out_distance),
    .out_velocity      (out_velocity),
    .out_temp_control  (out_temp_control)
  );

  cfd_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_sequence_res  (out_sequence_res),
    .out_detector_bias (out_detector_bias),
    .out_control_param (out_control_param),
    .out_frame_denoise (out_frame_denoise),
    .out_stride_diff   (out_stride_diff),
    .out_kernel_select (out_kernel_select),
    .out_power_switch  (out_power_switch),
    .out_distance      (out_distance),
    .out_velocity      (out_velocity),
    .out_temp_control  (out_temp_control),
    .fail_count        (fail_count),
    .results_waiting   (results_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_frame_start <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame(input logic bad_hdr, input logic bad_tail,
                            input logic bad_chk, input fill_t fill,
                            input logic use_start, input int len);
    logic [7:0]  fr [32];
    logic [15:0] csum;
    int          idx;
    csum = '0;
    for (int p = 0; p < 32; p++) begin
      case (fill)
        FILL_ZERO: fr[p] = 8'h00;
        FILL_ONES: fr[p] = 8'hFF;
        default:   fr[p] = 8'($urandom_range(0, 255));
      endcase
    end
    for (int p = 0; p < 4; p++) begin
      fr[p] = flag_now;
      fr[28 + p] = flag_now;
    end
    for (int p = 4; p < 26; p++) csum = csum + 16'(fr[p]);
    if (bad_chk) csum = csum ^ 16'($urandom_range(1, 65535));
    fr[26] = csum[7:0];
    fr[27] = csum[15:8];
    if (bad_hdr) begin
      idx = $urandom_range(0, 3);
      fr[idx] = fr[idx] ^ 8'($urandom_range(1, 255));
    end
    if (bad_tail) begin
      idx = $urandom_range(28, 31);
      fr[idx] = fr[idx] ^ 8'($urandom_range(1, 255));
    end
    for (int p = 0; p < len; p++) send_byte(fr[p], (p == 0) && use_start);
  endtask

  task automatic random_frame(inout int sent);
    int    pick;
    int    cut;
    int    shade;
    logic  bh, bt, bc, st;
    fill_t fill;
    pick = $urandom_range(0, 99);
    shade = $urandom_range(0, 99);
    quiet = ($urandom_range(0, 3) == 0);
    fill = (shade < 6) ? FILL_ZERO : (shade < 12) ? FILL_ONES : FILL_RANDOM;
    st = ($urandom_range(0, 4) != 0);
    bh = 1'b0;
    bt = 1'b0;
    bc = 1'b0;
    cut = 32;
    if (pick >= 92) begin
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end else begin
      if (pick >= 55 && pick < 82) begin
        do begin
          bh = 1'($urandom_range(0, 1));
          bt = 1'($urandom_range(0, 1));
          bc = 1'($urandom_range(0, 1));
        end while (!(bh || bt || bc));
      end else if (pick >= 82) begin
        cut = $urandom_range(1, 31);
      end
      send_frame(bh, bt, bc, fill, st, cut);
      sent += cut;
    end
  endtask

  task automatic drain_and_set(input logic [7:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    flag_now = v;
  endtask

  // The receiver draws a fresh stall after every result it takes.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!out_valid);
      if (hold_req > 0 && !held) begin
        out_ready <= 1'b0;
        for (int k = 0; k < hold_req; k++) @(posedge clk);
        held = 1'b1;
        out_ready <= 1'b1;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int         phase_bytes;
    logic [7:0] v;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 8'h00;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_frame_start <= 1'b0;
    quiet = 1'b0;
    hold_req = 0;
    flag_now = cfd_pkg::FLAG_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset flag byte.
    send_frame(1'b0, 1'b0, 1'b0, FILL_RANDOM, 1'b1, 32);
    send_frame(1'b0, 1'b0, 1'b0, FILL_ZERO, 1'b0, 32);
    send_frame(1'b0, 1'b0, 1'b0, FILL_ONES, 1'b1, 32);
    send_frame(1'b1, 1'b0, 1'b0, FILL_RANDOM, 1'b1, 32);
    send_frame(1'b0, 1'b1, 1'b0, FILL_RANDOM, 1'b1, 32);
    send_frame(1'b0, 1'b0, 1'b1, FILL_RANDOM, 1'b1, 32);
    send_frame(1'b1, 1'b1, 1'b1, FILL_ONES, 1'b1, 32);
    send_frame(1'b0, 1'b1, 1'b1, FILL_ZERO, 1'b1, 32);
    send_frame(1'b0, 1'b0, 1'b0, FILL_RANDOM, 1'b1, 13);
    send_frame(1'b0, 1'b0, 1'b0, FILL_RANDOM, 1'b1, 32);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       v = 8'h00;
        1:       v = 8'hFF;
        4:       v = cfd_pkg::FLAG_RESET;
        default: v = 8'($urandom_range(0, 255));
      endcase
      drain_and_set(v);
      if (phase == 1) hold_req = LONG_HOLD;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) random_frame(phase_bytes);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
